FILE: rtl/core/glyph_text_rasterizer_assert.svh
// Assertion macros shared by the glyph text rasterizer RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef GLYPH_TEXT_RASTERIZER_ASSERT_SVH
`define GLYPH_TEXT_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GTR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/gtr_pkg.sv
// Package for the glyph text rasterizer: result type, codes, FSM states,
// sizing constants and the 5x6 font table. No dependencies.
package gtr_pkg;

	localparam int GLYPH_COLUMNS_DEF = 5;
	localparam int GLYPH_ROWS_DEF    = 6;
	localparam int ROM_STRIDE        = 5;
	localparam int GLYPH_BITS        = 30;

	localparam logic [7:0]  FIRST_CODE  = 8'd32;
	localparam logic [7:0]  LAST_CODE   = 8'd126;
	localparam logic [11:0] X_MAX       = 12'd2047;
	localparam logic [3:0]  SCALE_RESET = 4'd1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_UNPRINTABLE = 2'd1,
		ST_DROPPED     = 2'd2
	} gtr_status_t;

	typedef enum logic [1:0] {
		GTR_IDLE,
		GTR_SCAN,
		GTR_STAT
	} gtr_state_t;

	typedef struct packed {
		logic        is_pixel;
		logic [11:0] pixel_x;
		logic [10:0] pixel_y;
		logic [7:0]  pixel_color;
		logic [1:0]  status;
		logic [10:0] next_x;
		logic        last;
	} gtr_result_t;

	// One pixel strobe from the scanner.
	typedef struct packed {
		logic        valid;
		logic [11:0] x;
		logic [10:0] y;
	} gtr_pix_t;

	// Font glyphs for codes 32 to 126; bit (col + row*5) is one pixel.
	localparam logic [31:0] FONT_ROM [0:94] = '{
		32'h00000000, 32'h08021084, 32'h0000294a, 32'h15f52bea,
		32'h08fa38be, 32'h33a22e60, 32'h2e94d8a6, 32'h00001084,
		32'h10421088, 32'h04421082, 32'h00a23880, 32'h00471000,
		32'h04420000, 32'h00070000, 32'h0c600000, 32'h02222200,
		32'h1d3ad72e, 32'h3e4214c4, 32'h3e22222e, 32'h1d18320f,
		32'h210fc888, 32'h1d183c3f, 32'h1d17844c, 32'h0222221f,
		32'h1d18ba2e, 32'h210f463e, 32'h0c6018c0, 32'h04401000,
		32'h10411100, 32'h00e03800, 32'h04441040, 32'h0802322e,
		32'h3c1ef62e, 32'h231fc544, 32'h1f18be2f, 32'h3c10862e,
		32'h1f18c62f, 32'h3e10bc3f, 32'h0210bc3f, 32'h1d1c843e,
		32'h2318fe31, 32'h3e42109f, 32'h0c94211f, 32'h23149d31,
		32'h3e108421, 32'h231ad6bb, 32'h239cd671, 32'h1d18c62e,
		32'h0217c62f, 32'h30eac62e, 32'h2297c62f, 32'h1d141a2e,
		32'h0842109f, 32'h1d18c631, 32'h08454631, 32'h375ad631,
		32'h22a21151, 32'h08421151, 32'h3e22221f, 32'h1842108c,
		32'h20820820, 32'h0c421086, 32'h00004544, 32'hbe000000,
		32'h00000082, 32'h1c97b000, 32'h0e949c21, 32'h1c10b800,
		32'h1c94b908, 32'h3c1fc5c0, 32'h42211c4c, 32'h4e87252e,
		32'h12949c21, 32'h0c210040, 32'h8c421004, 32'h12519521,
		32'h0c210842, 32'h235aac00, 32'h12949c00, 32'h0c949800,
		32'h4213a526, 32'h7087252e, 32'h02149800, 32'h0e837000,
		32'h0c213c42, 32'h0e94a400, 32'h0464a400, 32'h155ac400,
		32'h36426c00, 32'h4e872529, 32'h1e223c00, 32'h1843188c,
		32'h08421084, 32'h0c463086, 32'h0006d800
	};

endpackage

FILE: rtl/core/gtr_channels.sv
// Valid/ready channel interfaces of the glyph text rasterizer:
// character input, result output and the configuration write channel.
// Depends on nothing.
interface gtr_char_if;
	logic       valid;
	logic       ready;
	logic       string_start;
	logic [9:0] start_x;
	logic [9:0] start_y;
	logic [7:0] char_code;
	logic [7:0] color;

	modport source (output valid, string_start, start_x, start_y, char_code, color,
		input ready);
	modport sink (input valid, string_start, start_x, start_y, char_code, color,
		output ready);
endinterface

interface gtr_result_if;
	logic        valid;
	logic        ready;
	logic        is_pixel;
	logic [11:0] pixel_x;
	logic [10:0] pixel_y;
	logic [7:0]  pixel_color;
	logic [1:0]  status;
	logic [10:0] next_x;
	logic        last;

	modport source (output valid, is_pixel, pixel_x, pixel_y, pixel_color, status,
		next_x, last, input ready);
	modport sink (input valid, is_pixel, pixel_x, pixel_y, pixel_color, status,
		next_x, last, output ready);
endinterface

interface gtr_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/glyph_text_rasterizer.sv
// Glyph text rasterizer: one character per transfer, glyph shifted out one bit per cycle while
// the result register has room. Each set glyph bit gives one pixel result; after the last shift
// step the block leaves the scan state, then loads a status result (status, next_x, last).
// An unprintable or dropped character gives only the status result. A new character is taken only
// in the idle state; output stalls hold scan and status alike. Reset clears cursor and error latch,
// sets the scale to 1. Uses gtr_pkg, gtr_channels, gtr_scan, gtr_out_reg and the assert macros.
`include "glyph_text_rasterizer_assert.svh"

module glyph_text_rasterizer #(
	parameter int GLYPH_COLUMNS = gtr_pkg::GLYPH_COLUMNS_DEF,
	parameter int GLYPH_ROWS    = gtr_pkg::GLYPH_ROWS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	gtr_char_if.sink     char_in,
	gtr_result_if.source result_out,
	gtr_cfg_if.sink      cfg
);

	localparam int ADV_W = 4 + $clog2(GLYPH_COLUMNS + 1);

	gtr_pkg::gtr_state_t  state_q, state_d;
	gtr_pkg::gtr_status_t stat_q, stat_d;
	gtr_pkg::gtr_result_t res_d;
	gtr_pkg::gtr_pix_t    pix;

	logic [10:0] cursor_x_q, cur_x, next_x;
	logic [9:0]  cursor_y_q, cur_y;
	logic        failed_q, failed_eff;
	logic [3:0]  scale_q;
	logic [7:0]  color_q;
	logic        accept, printable, go_scan, scan_load, stat_load, room, scan_busy;
	logic [ADV_W-1:0] adv;
	logic [11:0] sum;
	logic [6:0]  rom_idx;
	logic [gtr_pkg::GLYPH_BITS-1:0] glyph;

	assign accept = char_in.valid && char_in.ready;

	// Cursor as seen by this character
	always_comb begin
		cur_x      = char_in.string_start ? {1'b0, char_in.start_x} : cursor_x_q;
		cur_y      = char_in.string_start ? char_in.start_y : cursor_y_q;
		failed_eff = char_in.string_start ? 1'b0 : failed_q;
		printable  = char_in.char_code inside {[gtr_pkg::FIRST_CODE : gtr_pkg::LAST_CODE]};
		go_scan    = !failed_eff && printable;
	end

	// Advanced cursor, saturated
	assign adv    = ADV_W'(scale_q) * ADV_W'(GLYPH_COLUMNS);
	assign sum    = {1'b0, cur_x} + 12'(adv);
	assign next_x = (sum > gtr_pkg::X_MAX) ? 11'(gtr_pkg::X_MAX) : sum[10:0];

	// Font lookup
	assign rom_idx = 7'(char_in.char_code - gtr_pkg::FIRST_CODE);
	assign glyph   = gtr_pkg::FONT_ROM[rom_idx][gtr_pkg::GLYPH_BITS-1:0];

	// Status code for this character
	always_comb begin
		if (failed_eff) begin
			stat_d = gtr_pkg::ST_DROPPED;
		end else if (!printable) begin
			stat_d = gtr_pkg::ST_UNPRINTABLE;
		end else begin
			stat_d = gtr_pkg::ST_OK;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gtr_pkg::GTR_IDLE: begin
				if (accept) begin
					state_d = go_scan ? gtr_pkg::GTR_SCAN : gtr_pkg::GTR_STAT;
				end
			end
			gtr_pkg::GTR_SCAN: begin
				if (!scan_busy) begin
					state_d = gtr_pkg::GTR_STAT;
				end
			end
			gtr_pkg::GTR_STAT: begin
				if (room) begin
					state_d = gtr_pkg::GTR_IDLE;
				end
			end
			default: state_d = gtr_pkg::GTR_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		char_in.ready = (state_q == gtr_pkg::GTR_IDLE);
		scan_load     = accept && go_scan;
		stat_load     = (state_q == gtr_pkg::GTR_STAT) && room;
	end

	// State, cursor, error latch and scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gtr_pkg::GTR_IDLE;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			failed_q   <= 1'b0;
			scale_q    <= gtr_pkg::SCALE_RESET;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cursor_x_q <= go_scan ? next_x : cur_x;
				cursor_y_q <= cur_y;
				failed_q   <= failed_eff || !printable;
			end
			if (cfg.valid && cfg.ready) begin
				scale_q <= cfg.data;
			end
		end
	end

	assign cfg.ready = 1'b1;

	// Hold per-character payload
	always_ff @(posedge clk) begin
		if (accept) begin
			stat_q  <= stat_d;
			color_q <= char_in.color;
		end
	end

	gtr_scan #(
		.GLYPH_COLUMNS (GLYPH_COLUMNS),
		.GLYPH_ROWS    (GLYPH_ROWS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (scan_load),
		.glyph  (glyph),
		.base_x (cur_x),
		.base_y (cur_y),
		.room   (room),
		.busy   (scan_busy),
		.pix    (pix)
	);

	// Pick pixel write or status for the result register
	always_comb begin
		res_d = '0;
		if (stat_load) begin
			res_d.status = stat_q;
			res_d.next_x = cursor_x_q;
			res_d.last   = 1'b1;
		end else begin
			res_d.is_pixel    = 1'b1;
			res_d.pixel_x     = pix.x;
			res_d.pixel_y     = pix.y;
			res_d.pixel_color = color_q;
		end
	end

	gtr_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (stat_load || pix.valid),
		.d          (res_d),
		.room       (room),
		.result_out (result_out)
	);

	`GTR_ASSERT_NEXT(a_accept_busy, accept, state_q != gtr_pkg::GTR_IDLE,
		"block idle right after a character transfer")
	`GTR_ASSERT_NOW(a_scan_in_state, scan_busy, state_q == gtr_pkg::GTR_SCAN,
		"scanner running outside the scan state")
	`GTR_ASSERT_NOW(a_one_source, pix.valid, !stat_load,
		"pixel and status offered in the same cycle")

endmodule

FILE: rtl/core/gtr_scan.sv
// Bit-serial glyph scanner: shifts the column-major glyph out one bit per
// cycle while room is high and tracks the pixel position. Uses gtr_pkg.
`include "glyph_text_rasterizer_assert.svh"

module gtr_scan #(
	parameter int GLYPH_COLUMNS = gtr_pkg::GLYPH_COLUMNS_DEF,
	parameter int GLYPH_ROWS    = gtr_pkg::GLYPH_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [gtr_pkg::GLYPH_BITS-1:0] glyph,
	input  logic [10:0]                   base_x,
	input  logic [9:0]                    base_y,
	input  logic                          room,
	output logic                          busy,
	output gtr_pkg::gtr_pix_t             pix
);

	localparam int N_BITS = GLYPH_COLUMNS * GLYPH_ROWS;
	localparam int CW     = $clog2(N_BITS + 1);
	localparam int RW     = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

	logic [N_BITS-1:0] perm;
	logic [N_BITS-1:0] sh_q;
	logic [CW-1:0]     cnt_q;
	logic [RW-1:0]     row_q;
	logic [11:0]       px_q;
	logic [10:0]       py_q;
	logic [9:0]        base_y_q;
	logic              busy_q;
	logic              step;

	// Reorder the glyph so that scan order is bit order; wide columns read blank
	for (genvar c = 0; c < GLYPH_COLUMNS; c++) begin : g_col
		for (genvar r = 0; r < GLYPH_ROWS; r++) begin : g_row
			if (c < gtr_pkg::ROM_STRIDE) begin : g_on
				assign perm[c*GLYPH_ROWS + r] = glyph[c + r*gtr_pkg::ROM_STRIDE];
			end else begin : g_off
				assign perm[c*GLYPH_ROWS + r] = 1'b0;
			end
		end
	end

	// Advance one bit whenever the result register can take a pixel
	assign step = busy_q && room;

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N_BITS);
		end else if (step) begin
			busy_q <= (cnt_q != CW'(1));
			cnt_q  <= cnt_q - CW'(1);
		end
	end

	// Shift line and position tracking
	always_ff @(posedge clk) begin
		if (load) begin
			sh_q     <= perm;
			row_q    <= '0;
			px_q     <= {1'b0, base_x};
			py_q     <= {1'b0, base_y};
			base_y_q <= base_y;
		end else if (step) begin
			sh_q <= sh_q >> 1;
			if (row_q == RW'(GLYPH_ROWS - 1)) begin
				row_q <= '0;
				px_q  <= px_q + 12'd1;
				py_q  <= {1'b0, base_y_q};
			end else begin
				row_q <= row_q + RW'(1);
				py_q  <= py_q + 11'd1;
			end
		end
	end

	assign busy      = busy_q;
	assign pix.valid = step && sh_q[0];
	assign pix.x     = px_q;
	assign pix.y     = py_q;

	`GTR_ASSERT_NOW(a_busy_count, busy_q, cnt_q != '0, "scanner busy with no bits left")
	`GTR_ASSERT_NOW(a_no_reload, load, !busy_q, "scanner reloaded while busy")

endmodule

FILE: rtl/core/gtr_out_reg.sv
// Result output register: holds one result and parts the scanner from a
// stalled consumer. Depends on gtr_pkg and gtr_channels.
`include "glyph_text_rasterizer_assert.svh"

module gtr_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  gtr_pkg::gtr_result_t d,
	output logic                 room,
	gtr_result_if.source         result_out
);

	logic                 valid_q;
	gtr_pkg::gtr_result_t data_q;

	// Free when empty or when the held result transfers this cycle
	assign room = !valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	assign result_out.valid       = valid_q;
	assign result_out.is_pixel    = data_q.is_pixel;
	assign result_out.pixel_x     = data_q.pixel_x;
	assign result_out.pixel_y     = data_q.pixel_y;
	assign result_out.pixel_color = data_q.pixel_color;
	assign result_out.status      = data_q.status;
	assign result_out.next_x      = data_q.next_x;
	assign result_out.last        = data_q.last;

	`GTR_ASSERT_NOW(a_no_overwrite, load, room, "result loaded over a pending result")

endmodule
